[hdl/rhht_pkg.sv]
// Shared types and constants of the robin hood hash table core.
package rhht_pkg;

	localparam int TableEntries = 1024;
	localparam int KeyBits = 32;
	localparam int ValueBits = 32;
	localparam int ProbeBits = 10;
	localparam int HashBits = 64;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_DELETE = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_NEW = 3'd0,
		ST_OVER = 3'd1,
		ST_FOUND = 3'd2,
		ST_MISS = 3'd3,
		ST_DEL = 3'd4,
		ST_FULL = 3'd5
	} status_t;

endpackage

[hdl/rhht_front.sv]
// Front end: accepts request beats, decodes the operation and queues them for the engine.
module rhht_front #(
	parameter int KEY_BITS = rhht_pkg::KeyBits,
	parameter int VALUE_BITS = rhht_pkg::ValueBits
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] in_func,
	input logic [rhht_pkg::HashBits-1:0] in_hash,
	input logic [KEY_BITS-1:0] in_key,
	input logic [VALUE_BITS-1:0] in_value,
	output logic q_valid,
	input logic q_ready,
	output rhht_pkg::func_t q_func,
	output logic [rhht_pkg::HashBits-1:0] q_hash,
	output logic [KEY_BITS-1:0] q_key,
	output logic [VALUE_BITS-1:0] q_value
);
	localparam int Depth = 2;
	localparam int W = 2 + rhht_pkg::HashBits + KEY_BITS + VALUE_BITS;

	logic [W-1:0] mem_q [Depth];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'(Depth));
	assign q_valid = (cnt_q != 2'd0);
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= {in_value, in_key, in_hash, in_func};
	end

	assign q_func = rhht_pkg::func_t'(mem_q[rd_q][1:0]);
	assign q_hash = mem_q[rd_q][rhht_pkg::HashBits+1:2];
	assign q_key = mem_q[rd_q][rhht_pkg::HashBits+KEY_BITS+1:rhht_pkg::HashBits+2];
	assign q_value = mem_q[rd_q][W-1:rhht_pkg::HashBits+KEY_BITS+2];

`ifndef NO_ASSERTIONS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(Depth))
		else $error("queue count overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(Depth) && !pop) |=> !in_ready) else $error("full queue opened");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !push) |=> !q_valid) else $error("empty queue valid");
`endif
endmodule

[hdl/rhht_engine.sv]
// Back end: sequencer that walks the slot memory for insert, lookup and delete.
module rhht_engine #(
	parameter int TABLE_ENTRIES = rhht_pkg::TableEntries,
	parameter int KEY_BITS = rhht_pkg::KeyBits,
	parameter int VALUE_BITS = rhht_pkg::ValueBits,
	parameter int PROBE_BITS = rhht_pkg::ProbeBits,
	localparam int IB = $clog2(TABLE_ENTRIES),
	localparam int CB = $clog2(TABLE_ENTRIES + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input rhht_pkg::func_t q_func,
	input logic [rhht_pkg::HashBits-1:0] q_hash,
	input logic [KEY_BITS-1:0] q_key,
	input logic [VALUE_BITS-1:0] q_value,
	output logic out_valid,
	input logic out_ready,
	output rhht_pkg::status_t out_status,
	output logic [VALUE_BITS-1:0] out_value,
	output logic [CB-1:0] out_total,
	output logic busy
);
	localparam int HB = rhht_pkg::HashBits;
	localparam int PB = PROBE_BITS;
	localparam logic [PB-1:0] ProbeMax = '1;
	localparam int EW = PB + HB + KEY_BITS + VALUE_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_RD, S_CHK, S_DRD, S_DCHK, S_WR, S_OUT
	} state_t;

	// Slot memory: probe, hash, key, value. Used bits in flip-flops are too
	// many for large tables, so a clearing pass after reset zeroes the
	// probe/used memory instead.
	logic [EW-1:0] slot_mem [TABLE_ENTRIES];
	logic used_mem [TABLE_ENTRIES];
	logic [EW-1:0] rd_ent;
	logic rd_used;
	logic [IB-1:0] rd_addr, wr_addr;
	logic rd_en, wr_en, wr_used;
	logic [EW-1:0] wr_ent;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_ent;
			used_mem[wr_addr] <= wr_used;
		end
		if (rd_en) begin
			rd_ent <= slot_mem[rd_addr];
			rd_used <= used_mem[rd_addr];
		end
	end

	state_t state_q;
	rhht_pkg::func_t func_q;
	logic commit_q;
	logic [IB-1:0] start_q, idx_q, clr_q;
	logic [IB:0] step_q;
	logic [PB:0] cp_q;
	logic [HB-1:0] ch_q, h_q;
	logic [KEY_BITS-1:0] ck_q, k_q;
	logic [VALUE_BITS-1:0] cv_q, v_q;
	logic [CB-1:0] count_q;
	rhht_pkg::status_t st_q;
	logic [VALUE_BITS-1:0] vo_q;
	logic del_done_q;

	logic [PB-1:0] r_probe;
	logic [HB-1:0] r_hash;
	logic [KEY_BITS-1:0] r_key;
	logic [VALUE_BITS-1:0] r_value;
	assign {r_probe, r_hash, r_key, r_value} = rd_ent;

	logic match;
	assign match = (r_hash == ch_q) && (r_key == ck_q);

	assign q_ready = (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_status = st_q;
	assign out_value = vo_q;
	assign out_total = count_q;

	// Memory port control is combinational from the registered state.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_used = 1'b1;
		wr_ent = {cp_q[PB-1:0], ch_q, ck_q, cv_q};
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_used = 1'b0;
				wr_ent = '0;
			end
			S_RD, S_DRD: rd_en = 1'b1;
			S_CHK: begin
				if (commit_q && cp_q <= {1'b0, ProbeMax}) begin
					if (!rd_used || match) wr_en = 1'b1;
					else if (cp_q[PB-1:0] > r_probe) wr_en = 1'b1;
				end else if (func_q == rhht_pkg::FUNC_INSERT &&
				    count_q >= CB'(TABLE_ENTRIES) &&
				    step_q != (IB+1)'(TABLE_ENTRIES) && rd_used && match &&
				    cp_q <= {1'b0, r_probe}) begin
					// Full table: only the stored value of a found key changes.
					wr_en = 1'b1;
					wr_ent = {r_probe, r_hash, r_key, cv_q};
				end
			end
			S_DCHK: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
				if (!rd_used || r_probe == '0 || step_q == (IB+1)'(TABLE_ENTRIES)) begin
					wr_used = 1'b0;
					wr_ent = '0;
				end else
					wr_ent = {r_probe - PB'(1), r_hash, r_key, r_value};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + IB'(1);
					if (idx_q == IB'(TABLE_ENTRIES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (q_valid) begin
					func_q <= q_func;
					h_q <= q_hash; k_q <= q_key; v_q <= q_value;
					ch_q <= q_hash; ck_q <= q_key; cv_q <= q_value;
					start_q <= q_hash[IB-1:0];
					idx_q <= q_hash[IB-1:0];
					cp_q <= '0;
					step_q <= '0;
					commit_q <= 1'b0;
					vo_q <= '0;
					st_q <= rhht_pkg::ST_MISS;
					state_q <= (q_func == rhht_pkg::FUNC_NONE) ? S_OUT : S_RD;
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					// Insert in a full table behaves as a lookup with overwrite.
					logic ins, fullmode;
					ins = (func_q == rhht_pkg::FUNC_INSERT);
					fullmode = !ins || count_q >= CB'(TABLE_ENTRIES);
					if (step_q == (IB+1)'(TABLE_ENTRIES) ||
					    (ins && !fullmode && cp_q > {1'b0, ProbeMax})) begin
						st_q <= ins ? rhht_pkg::ST_FULL : rhht_pkg::ST_MISS;
						state_q <= S_OUT;
					end else if (fullmode && (!rd_used || cp_q > {1'b0, r_probe})) begin
						st_q <= ins ? rhht_pkg::ST_FULL : rhht_pkg::ST_MISS;
						state_q <= S_OUT;
					end else if (!rd_used) begin
						if (commit_q) begin
							st_q <= rhht_pkg::ST_NEW;
							count_q <= count_q + CB'(1);
							state_q <= S_OUT;
						end else begin
							commit_q <= 1'b1;
							ch_q <= h_q; ck_q <= k_q; cv_q <= v_q;
							idx_q <= start_q; cp_q <= '0; step_q <= '0;
							state_q <= S_RD;
						end
					end else if (match) begin
						if (func_q == rhht_pkg::FUNC_LOOKUP) begin
							st_q <= rhht_pkg::ST_FOUND;
							vo_q <= r_value;
							state_q <= S_OUT;
						end else if (func_q == rhht_pkg::FUNC_DELETE) begin
							clr_q <= idx_q;
							idx_q <= idx_q + IB'(1);
							step_q <= (IB+1)'(1);
							state_q <= S_DRD;
						end else if (commit_q || fullmode) begin
							st_q <= rhht_pkg::ST_OVER;
							state_q <= S_OUT;
						end else begin
							commit_q <= 1'b1;
							ch_q <= h_q; ck_q <= k_q; cv_q <= v_q;
							idx_q <= start_q; cp_q <= '0; step_q <= '0;
							state_q <= S_RD;
						end
					end else begin
						if (ins && cp_q > {1'b0, r_probe}) begin
							ch_q <= r_hash; ck_q <= r_key; cv_q <= r_value;
							cp_q <= {1'b0, r_probe} + (PB+1)'(1);
						end else
							cp_q <= cp_q + (PB+1)'(1);
						idx_q <= idx_q + IB'(1);
						step_q <= step_q + (IB+1)'(1);
						state_q <= S_RD;
					end
				end
				S_DRD: state_q <= S_DCHK;
				S_DCHK: begin
					if (!rd_used || r_probe == '0 || step_q == (IB+1)'(TABLE_ENTRIES)) begin
						st_q <= rhht_pkg::ST_DEL;
						if (count_q != '0) count_q <= count_q - CB'(1);
						state_q <= S_OUT;
					end else begin
						clr_q <= idx_q;
						idx_q <= idx_q + IB'(1);
						step_q <= step_q + (IB+1)'(1);
						state_q <= S_DRD;
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign del_done_q = 1'b0;

`ifndef NO_ASSERTIONS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(TABLE_ENTRIES)) else $error("entry count above table size");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(st_q) && $stable(count_q)))
		else $error("result changed while stalled");
	a_val: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && st_q != rhht_pkg::ST_FOUND) |-> vo_q == '0)
		else $error("value on non-found result");
	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && $past(state_q) == S_RD && !del_done_q) |-> !out_valid)
		else $error("result during probe");
`endif
endmodule

[hdl/robin_hood_hash_table_core.sv]
// Top level of the robin hood hash table core.
// Robin hood open-addressing hash table with backward-shift delete. A request
// beat carries an operation, a precomputed hash, a key and a value; one result
// beat returns status, found value and entry count. Requests enter a two-deep
// queue so the upstream side is released while the probe sequencer works.
// Each visited slot takes a registered memory read, then a check. Lookup and
// delete walk the probe sequence once; an insert walks twice (a trial walk,
// then the committing walk) unless the table is full; delete then reads and
// checks each shifted entry and the slot that ends the run. The slot memory
// has a single read port. After reset a clearing pass over all TABLE_ENTRIES
// slots runs before the first request is taken.
module robin_hood_hash_table_core #(
	parameter int TABLE_ENTRIES = rhht_pkg::TableEntries,
	parameter int KEY_BITS = rhht_pkg::KeyBits,
	parameter int VALUE_BITS = rhht_pkg::ValueBits,
	parameter int PROBE_BITS = rhht_pkg::ProbeBits,
	localparam int CB = $clog2(TABLE_ENTRIES + 1),
	localparam int IW = ((2 + rhht_pkg::HashBits + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
	localparam int OW = ((3 + VALUE_BITS + CB + 7) / 8) * 8
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// func, key_hash, key, value_in from bit 0 up
	input logic [IW-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status, value_out, entry_total from bit 0 up
	output logic [OW-1:0] m_tdata
);
	localparam int HB = rhht_pkg::HashBits;

	rhht_pkg::func_t q_func;
	logic q_valid, q_ready, busy;
	logic [HB-1:0] q_hash;
	logic [KEY_BITS-1:0] q_key;
	logic [VALUE_BITS-1:0] q_value;
	rhht_pkg::status_t st;
	logic [VALUE_BITS-1:0] vo;
	logic [CB-1:0] total;

	rhht_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_func(s_tdata[1:0]),
		.in_hash(s_tdata[HB+1:2]),
		.in_key(s_tdata[HB+KEY_BITS+1:HB+2]),
		.in_value(s_tdata[HB+KEY_BITS+VALUE_BITS+1:HB+KEY_BITS+2]),
		.q_valid, .q_ready, .q_func, .q_hash, .q_key, .q_value
	);

	rhht_engine #(
		.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BITS(KEY_BITS),
		.VALUE_BITS(VALUE_BITS), .PROBE_BITS(PROBE_BITS)
	) u_engine (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_func, .q_hash, .q_key, .q_value,
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_status(st), .out_value(vo), .out_total(total), .busy
	);

	assign m_tdata = OW'({total, vo, st});

`ifndef NO_ASSERTIONS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> busy)
		else $error("result without active request");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd5) else $error("bad status code");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
`endif
endmodule
